/* rtl/mesi_pkg.sv */
package mesi_pkg;

  localparam int unsigned WAYS_DEF     = 4;
  localparam int unsigned SET_BITS_DEF = 6;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned OFS_W        = 4;
  localparam logic [3:0]  OFS_RESET    = 4'd5;
  localparam logic [3:0]  OFS_MIN      = 4'd2;
  localparam logic [3:0]  OFS_MAX      = 4'd10;

  // operation codes
  localparam logic [2:0] OP_CPU_RD   = 3'd0;
  localparam logic [2:0] OP_CPU_WR   = 3'd1;
  localparam logic [2:0] OP_SN_RD    = 3'd2;
  localparam logic [2:0] OP_SN_RDX   = 3'd3;
  localparam logic [2:0] OP_SN_UPGR  = 3'd4;
  // unused codes, ignored by the block
  localparam logic [2:0] OP_RSV_FIRST = 3'd5;
  localparam logic [2:0] OP_RSV_LAST  = 3'd7;

  // line states
  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;

  // bus requests
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_RD   = 2'd1;
  localparam logic [1:0] REQ_RDX  = 2'd2;
  localparam logic [1:0] REQ_UPGR = 2'd3;

  // stall kinds
  localparam logic [1:0] STALL_NONE    = 2'd0;
  localparam logic [1:0] STALL_BLOCKED = 2'd1;
  localparam logic [1:0] STALL_BUSY    = 2'd2;

  localparam logic [9:0] CYC_MEM  = 10'd100;
  localparam logic [9:0] CYC_MEM2 = 10'd200;

  // first member in the highest bits, so accepted lands in bit 0
  typedef struct packed {
    logic [11:0] bus_bytes;
    logic [1:0]  fill_state;
    logic [9:0]  xfer_cycles;
    logic [31:0] bus_address;
    logic [1:0]  bus_request;
    logic        writeback;
    logic        eviction;
    logic [1:0]  stall_kind;
    logic        hit;
    logic        accepted;
  } result_t;

endpackage

/* rtl/mesi_l1_cache_controller_unit.sv */
// MESI snooping L1 cache controller, set-associative with LRU stamps. One
// beat in, one result beat out. At the edge that accepts an input beat, the
// lines of its set are read from the set memory into a register; the result
// is registered once the result register is free or taken, and the result
// beat is offered from that register. A new beat can be accepted every cycle;
// while a result beat waits on m_axis_tready_i, s_axis_tready_o is low in the
// same cycle. An item's line update is passed straight to a following item of
// the same set. After reset a clearing pass over the 1 << SET_BITS sets (64
// with the defaults) sets all lines invalid with stamps all ones, and
// s_axis_tready_o stays low until it is done. Write the offset register only
// while no beat is in flight. tdata/tuser packing is listed at the ports.
module mesi_l1_cache_controller_unit #(
  parameter int unsigned WAYS     = mesi_pkg::WAYS_DEF,
  parameter int unsigned SET_BITS = mesi_pkg::SET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] address, [63:32] cycle_stamp, [64] bus_busy, [65] core_blocked,
  // [66] other_has_copy, [67] other_has_modified, [71:68] zero
  input  logic [71:0] s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] accepted, [1] hit, [3:2] stall_kind, [4] eviction, [5] writeback,
  // [7:6] bus_request, [39:8] bus_address, [49:40] xfer_cycles,
  // [51:50] fill_state, [63:52] bus_bytes
  output logic [63:0] m_axis_tdata_o
);

  localparam int unsigned NSETS  = 1 << SET_BITS;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SET_W  = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned TAG_W  = 32 - SET_BITS - 2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [1:0]       st;
    logic [31:0]      stp;
  } line_t;
  typedef line_t [WAYS-1:0] set_t;

  function automatic logic [3:0] sat_ofs(logic [3:0] v);
    if (v < mesi_pkg::OFS_MIN) return mesi_pkg::OFS_MIN;
    if (v > mesi_pkg::OFS_MAX) return mesi_pkg::OFS_MAX;
    return v;
  endfunction

  logic [3:0] ofs_q, ofs_d;
  logic       in_v_q, out_v_q;
  logic [2:0] op_q;
  logic [71:0] in_q;
  mesi_pkg::result_t res_q, res_d;
  logic       clr_busy_q;
  logic [SET_W-1:0] clr_q;

  // all ways of one set per word
  set_t set_mem [NSETS];
  set_t rd_q, wset, clr_set;

  // pipeline advances when the result register is free or taken
  logic adv;
  assign adv = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv && !clr_busy_q;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = res_q;

  // set of the incoming beat, with the offset in force after this edge
  logic [3:0] nb;
  logic [SET_W-1:0] rset;
  assign ofs_d = cfg_valid_i ? cfg_data_i : ofs_q;
  assign nb = sat_ofs(ofs_d);
  assign rset = SET_W'((s_axis_tdata_i[31:0] >> nb) & ((32'd1 << SET_BITS) - 32'd1));

  // decoded fields
  logic [31:0] addr, stamp;
  logic busy, blocked, ocopy, omod;
  logic [3:0] b;
  logic [11:0] bsize;
  logic [31:0] tag_full;
  logic [TAG_W-1:0] tag;
  logic [SET_W-1:0] set_w;
  assign addr    = in_q[31:0];
  assign stamp   = in_q[63:32];
  assign busy    = in_q[64];
  assign blocked = in_q[65];
  assign ocopy   = in_q[66];
  assign omod    = in_q[67];
  assign b = sat_ofs(ofs_q);
  assign bsize = 12'd1 << b;
  assign tag_full = addr >> (SET_BITS + b);
  assign tag = tag_full[TAG_W-1:0];
  assign set_w = SET_W'((addr >> b) & ((32'd1 << SET_BITS) - 32'd1));

  // word written by the clearing pass
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_set[w].tag = '0;
      clr_set[w].st  = mesi_pkg::ST_I;
      clr_set[w].stp = '1;
    end
  end

  // one pass: lookup, victim choice, response
  logic hit_f, inv_f, wr_en, mem_we;
  logic [WAY_W-1:0] hway, iway, lway, vway, wway;
  logic [TAG_W-1:0] wtag;
  logic [1:0] wst;
  logic wstp;
  always_comb begin
    logic [31:0] best;
    hit_f = 1'b0; inv_f = 1'b0; hway = '0; iway = '0; lway = '0;
    best = rd_q[0].stp;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_q[w].st != mesi_pkg::ST_I && rd_q[w].tag == tag) begin
        hit_f = 1'b1; hway = WAY_W'(w);
      end
      if (rd_q[w].st == mesi_pkg::ST_I) begin
        inv_f = 1'b1; iway = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (rd_q[w].stp <= best) begin
        best = rd_q[w].stp; lway = WAY_W'(w);
      end
    end
    vway = inv_f ? iway : lway;
    res_d = '0; wr_en = 1'b0; wway = hway; wtag = rd_q[hway].tag; wst = rd_q[hway].st;
    wstp = 1'b0;
    if (op_q == mesi_pkg::OP_CPU_RD || op_q == mesi_pkg::OP_CPU_WR) begin
      if (hit_f) begin
        res_d.hit = 1'b1; wr_en = 1'b1; wstp = 1'b1;
        if (op_q == mesi_pkg::OP_CPU_WR && rd_q[hway].st == mesi_pkg::ST_S && busy) begin
          res_d.stall_kind = blocked ? mesi_pkg::STALL_BLOCKED : mesi_pkg::STALL_BUSY;
        end else begin
          res_d.accepted = 1'b1;
          if (op_q == mesi_pkg::OP_CPU_WR) begin
            if (rd_q[hway].st == mesi_pkg::ST_S) begin
              res_d.bus_request = mesi_pkg::REQ_UPGR;
              res_d.bus_address = addr;
            end
            wst = mesi_pkg::ST_M;
          end
        end
      end else if (busy) begin
        res_d.stall_kind = blocked ? mesi_pkg::STALL_BLOCKED : mesi_pkg::STALL_BUSY;
      end else begin
        res_d.eviction = !inv_f;
        wr_en = 1'b1; wway = vway; wtag = rd_q[vway].tag; wst = rd_q[vway].st;
        if (!inv_f && rd_q[vway].st == mesi_pkg::ST_M) begin
          res_d.writeback = 1'b1;
          res_d.bus_bytes = bsize;
          res_d.bus_request = mesi_pkg::REQ_RDX;
          res_d.bus_address = (32'(rd_q[vway].tag) << (SET_BITS + b)) | (32'(set_w) << b);
          res_d.xfer_cycles = mesi_pkg::CYC_MEM;
          wst = mesi_pkg::ST_I;
        end else begin
          res_d.accepted = 1'b1; wtag = tag; wstp = 1'b1;
          res_d.bus_address = addr;
          if (op_q == mesi_pkg::OP_CPU_RD) begin
            res_d.bus_request = mesi_pkg::REQ_RD;
            res_d.bus_bytes = bsize;
            if (omod) begin
              res_d.xfer_cycles = bsize[11:2] + bsize[11:2] + mesi_pkg::CYC_MEM;
              res_d.writeback = 1'b1; res_d.fill_state = mesi_pkg::ST_S;
            end else if (ocopy) begin
              res_d.xfer_cycles = bsize[11:2] + bsize[11:2];
              res_d.fill_state = mesi_pkg::ST_S;
            end else begin
              res_d.xfer_cycles = mesi_pkg::CYC_MEM;
              res_d.fill_state = mesi_pkg::ST_E;
            end
          end else begin
            res_d.bus_request = mesi_pkg::REQ_RDX;
            res_d.fill_state = mesi_pkg::ST_M;
            if (omod) begin
              res_d.xfer_cycles = mesi_pkg::CYC_MEM2;
              res_d.writeback = 1'b1; res_d.bus_bytes = bsize << 1;
            end else begin
              res_d.xfer_cycles = mesi_pkg::CYC_MEM;
              res_d.bus_bytes = bsize;
            end
          end
          wst = res_d.fill_state;
        end
      end
    end else if (op_q == mesi_pkg::OP_SN_RD || op_q == mesi_pkg::OP_SN_RDX ||
                 op_q == mesi_pkg::OP_SN_UPGR) begin
      res_d.accepted = 1'b1;
      if (hit_f) begin
        res_d.hit = 1'b1; wr_en = 1'b1;
        if (op_q == mesi_pkg::OP_SN_RD) begin
          if (rd_q[hway].st == mesi_pkg::ST_M) begin
            res_d.writeback = 1'b1; res_d.bus_bytes = bsize; wst = mesi_pkg::ST_S;
          end else if (rd_q[hway].st == mesi_pkg::ST_E) begin
            wst = mesi_pkg::ST_S;
          end
        end else begin
          wst = mesi_pkg::ST_I;
        end
      end
    end
    // updated set word
    wset = rd_q;
    wset[wway].tag = wtag;
    wset[wway].st = wst;
    if (wstp) wset[wway].stp = stamp;
  end

  assign mem_we = adv && in_v_q && wr_en;

  // control registers and clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= mesi_pkg::OFS_RESET;
      in_v_q <= 1'b0;
      out_v_q <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_q <= '0;
    end else begin
      if (cfg_valid_i) ofs_q <= cfg_data_i;
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == SET_W'(NSETS - 1)) clr_busy_q <= 1'b0;
      end
      if (adv) begin
        in_v_q <= s_axis_tvalid_i && s_axis_tready_o;
        out_v_q <= in_v_q;
      end
    end
  end

  // set memory: one write and one registered read per cycle, the read only while the pipeline advances
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      set_mem[clr_q] <= clr_set;
    end else if (mem_we) begin
      set_mem[set_w] <= wset;
    end
    if (adv) begin
      if (mem_we && set_w == rset) rd_q <= wset;
      else rd_q <= set_mem[rset];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= s_axis_tdata_i;
      op_q <= s_axis_tuser_i;
      res_q <= res_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready_i |=> out_v_q && $stable(res_q))
    else $error("result lost under stall");
  a_acc_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(res_q.accepted && res_q.stall_kind != mesi_pkg::STALL_NONE))
    else $error("accepted item reports a stall");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.fill_state != mesi_pkg::ST_I |-> res_q.accepted && !res_q.hit)
    else $error("fill without miss");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NWAYS  = mesi_pkg::WAYS_DEF;
  localparam int unsigned NSETB  = mesi_pkg::SET_BITS_DEF;
  localparam int unsigned NLINE  = NWAYS << NSETB;
  localparam int unsigned LIMIT  = 400000;
  localparam int unsigned NRAND  = 1600;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;

  mesi_l1_cache_controller_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  // one access or snoop beat
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] stamp;
    logic        busy;
    logic        blocked;
    logic        other_copy;
    logic        other_mod;
  } access_t;

  // Cache shadow: predicts result beats and queues them.
  class cache_scoreboard;
    logic [31:0] tag_q [NLINE];
    logic [1:0]  state_q [NLINE];
    logic [31:0] stamp_q [NLINE];
    logic [3:0]  ofs_reg;
    mesi_pkg::result_t pending [$];
    int          errors;

    function new();
      for (int i = 0; i < NLINE; i++) begin
        tag_q[i] = '0; state_q[i] = mesi_pkg::ST_I; stamp_q[i] = '1;
      end
      ofs_reg = mesi_pkg::OFS_RESET;
      errors = 0;
    endfunction

    function int find_way(int set, logic [31:0] tag);
      for (int w = 0; w < NWAYS; w++)
        if (state_q[set*NWAYS+w] != mesi_pkg::ST_I && tag_q[set*NWAYS+w] == tag) return w;
      return NWAYS;
    endfunction

    // predict the result of one accepted beat
    function void note_access(access_t a);
      mesi_pkg::result_t r;
      int set, way, idx, best;
      logic [3:0] b;
      logic [11:0] bsize;
      logic [31:0] tag;
      r = '0;
      b = ofs_reg < mesi_pkg::OFS_MIN ? mesi_pkg::OFS_MIN :
          (ofs_reg > mesi_pkg::OFS_MAX ? mesi_pkg::OFS_MAX : ofs_reg);
      bsize = 12'd1 << b;
      tag = a.addr >> (NSETB + b);
      set = (a.addr >> b) & ((1 << NSETB) - 1);
      if (a.op == mesi_pkg::OP_CPU_RD || a.op == mesi_pkg::OP_CPU_WR) begin
        way = find_way(set, tag);
        if (way < NWAYS) begin
          idx = set*NWAYS + way;
          r.hit = 1'b1;
          stamp_q[idx] = a.stamp;
          if (a.op == mesi_pkg::OP_CPU_WR && state_q[idx] == mesi_pkg::ST_S && a.busy) begin
            r.stall_kind = a.blocked ? mesi_pkg::STALL_BLOCKED : mesi_pkg::STALL_BUSY;
          end else begin
            r.accepted = 1'b1;
            if (a.op == mesi_pkg::OP_CPU_WR) begin
              if (state_q[idx] == mesi_pkg::ST_S) begin
                r.bus_request = mesi_pkg::REQ_UPGR; r.bus_address = a.addr;
              end
              state_q[idx] = mesi_pkg::ST_M;
            end
          end
        end else if (a.busy) begin
          r.stall_kind = a.blocked ? mesi_pkg::STALL_BLOCKED : mesi_pkg::STALL_BUSY;
        end else begin
          way = NWAYS;
          for (int w = 0; w < NWAYS; w++)
            if (way == NWAYS && state_q[set*NWAYS+w] == mesi_pkg::ST_I) way = w;
          if (way == NWAYS) begin
            best = 0;
            for (int w = 1; w < NWAYS; w++)
              if (stamp_q[set*NWAYS+w] <= stamp_q[set*NWAYS+best]) best = w;
            way = best;
            r.eviction = 1'b1;
          end
          idx = set*NWAYS + way;
          if (r.eviction && state_q[idx] == mesi_pkg::ST_M) begin
            // dirty victim goes out first, access not accepted
            r.writeback = 1'b1; r.bus_bytes = bsize; r.bus_request = mesi_pkg::REQ_RDX;
            r.bus_address = (tag_q[idx] << (NSETB + b)) | (set << b);
            r.xfer_cycles = mesi_pkg::CYC_MEM;
            state_q[idx] = mesi_pkg::ST_I;
          end else begin
            r.accepted = 1'b1;
            tag_q[idx] = tag; stamp_q[idx] = a.stamp;
            r.bus_address = a.addr;
            if (a.op == mesi_pkg::OP_CPU_RD) begin
              r.bus_request = mesi_pkg::REQ_RD; r.bus_bytes = bsize;
              if (a.other_mod) begin
                r.xfer_cycles = 10'(2*bsize/4 + 100); r.writeback = 1'b1;
                r.fill_state = mesi_pkg::ST_S;
              end else if (a.other_copy) begin
                r.xfer_cycles = 10'(2*bsize/4); r.fill_state = mesi_pkg::ST_S;
              end else begin
                r.xfer_cycles = mesi_pkg::CYC_MEM; r.fill_state = mesi_pkg::ST_E;
              end
            end else begin
              r.bus_request = mesi_pkg::REQ_RDX; r.fill_state = mesi_pkg::ST_M;
              if (a.other_mod) begin
                r.xfer_cycles = mesi_pkg::CYC_MEM2; r.writeback = 1'b1;
                r.bus_bytes = 12'(2*bsize);
              end else begin
                r.xfer_cycles = mesi_pkg::CYC_MEM; r.bus_bytes = bsize;
              end
            end
            state_q[idx] = r.fill_state;
          end
        end
      end else if (a.op <= mesi_pkg::OP_SN_UPGR) begin
        r.accepted = 1'b1;
        way = find_way(set, tag);
        if (way < NWAYS) begin
          idx = set*NWAYS + way;
          r.hit = 1'b1;
          if (a.op == mesi_pkg::OP_SN_RD) begin
            if (state_q[idx] == mesi_pkg::ST_M) begin
              r.writeback = 1'b1; r.bus_bytes = bsize; state_q[idx] = mesi_pkg::ST_S;
            end else if (state_q[idx] == mesi_pkg::ST_E) state_q[idx] = mesi_pkg::ST_S;
          end else state_q[idx] = mesi_pkg::ST_I;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(mesi_pkg::result_t got);
      mesi_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  cache_scoreboard sb;
  bit              hold_off;
  bit              calm;
  int unsigned     cyc_count = 0;
  int unsigned     stamp_ctr = 1;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: sample on rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_access({s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[63:32],
                        s_axis_tdata_i[64], s_axis_tdata_i[65], s_axis_tdata_i[66],
                        s_axis_tdata_i[67]});
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (cfg_valid_i && cfg_ready_o) sb.ofs_reg = cfg_data_i;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if (calm) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(99) >= 7);
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // current stamp, then step it
  function automatic logic [31:0] next_stamp();
    logic [31:0] s;
    s = stamp_ctr;
    stamp_ctr = stamp_ctr + 1;
    return s;
  endfunction

  task automatic send_beat(access_t a);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= a.op;
    s_axis_tdata_i  <= {4'd0, a.other_mod, a.other_copy, a.blocked, a.busy, a.stamp, a.addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_offset(logic [3:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random beat, mostly cpu accesses into a few hot sets and tags
  function automatic access_t rand_access(int unsigned stamp);
    access_t a;
    int unsigned k;
    k = $urandom_range(99);
    a.op = k < 40 ? mesi_pkg::OP_CPU_RD : k < 72 ? mesi_pkg::OP_CPU_WR :
           k < 80 ? mesi_pkg::OP_SN_RD : k < 88 ? mesi_pkg::OP_SN_RDX :
           k < 96 ? mesi_pkg::OP_SN_UPGR :
           3'($urandom_range(mesi_pkg::OP_RSV_LAST, mesi_pkg::OP_RSV_FIRST));
    if ($urandom_range(9) < 8) begin
      // small tag and set space so ways fill and evict
      a.addr = ($urandom_range(7) << 22) | ($urandom_range(3) << 16) |
               ($urandom_range(3) << 10) | ($urandom_range(3) << 5) | $urandom_range(31);
      a.addr = a.addr ^ ($urandom_range(1) ? 32'h8000_0000 : 32'h0);
    end else a.addr = $urandom;
    a.stamp = ($urandom_range(19) == 0) ? $urandom : stamp;
    a.busy = ($urandom_range(4) == 0);
    a.blocked = 1'($urandom_range(1));
    a.other_copy = 1'($urandom_range(1));
    a.other_mod = ($urandom_range(3) == 0);
    return a;
  endfunction

  initial begin
    access_t a;
    logic [3:0] ofs_set [6] = '{4'd5, 4'd2, 4'd10, 4'd0, 4'd15, 4'd7};
    sb = new();
    rst_ni = 0; cfg_valid_i = 0; cfg_data_i = '0; s_axis_tvalid_i = 0;
    s_axis_tdata_i = '0; s_axis_tuser_i = '0;
    hold_off = 0; calm = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: fill one set beyond its ways, upgrade, snoops, extremes
    calm = 1;
    for (int i = 0; i < 5; i++) begin
      a = '{mesi_pkg::OP_CPU_RD, (i << 11) | 32'h20, next_stamp(), 1'b0, 1'b0, i[0], i[1]};
      send_beat(a);
    end
    send_beat('{mesi_pkg::OP_CPU_WR, 32'h0000_0820, next_stamp(), 1'b1, 1'b1, 1'b0, 1'b0});
    send_beat('{mesi_pkg::OP_CPU_WR, 32'h0000_0820, next_stamp(), 1'b1, 1'b0, 1'b0, 1'b0});
    send_beat('{mesi_pkg::OP_CPU_WR, 32'h0000_0820, next_stamp(), 1'b0, 1'b0, 1'b0, 1'b0});
    send_beat('{mesi_pkg::OP_CPU_WR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1});
    send_beat('{mesi_pkg::OP_CPU_RD, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 1'b1, 1'b1});
    send_beat('{mesi_pkg::OP_CPU_RD, 32'h0000_0000, 32'h0, 1'b1, 1'b0, 1'b1, 1'b1});
    send_beat('{mesi_pkg::OP_SN_RD, 32'hFFFF_FFFF, next_stamp(), 1'b0, 1'b0, 1'b0, 1'b0});
    send_beat('{mesi_pkg::OP_SN_RD, 32'h0000_1020, next_stamp(), 1'b0, 1'b0, 1'b0, 1'b0});
    send_beat('{mesi_pkg::OP_SN_RDX, 32'h0000_0820, next_stamp(), 1'b0, 1'b0, 1'b0, 1'b0});
    send_beat('{mesi_pkg::OP_SN_UPGR, 32'h0000_1820, next_stamp(), 1'b0, 1'b0, 1'b0, 1'b0});
    for (int i = 0; i < 5; i++)
      send_beat('{mesi_pkg::OP_CPU_WR, (i << 12) | 32'h40, next_stamp(), 1'b0, 1'b0, 1'b0,
                  i[0]});
    send_beat('{mesi_pkg::OP_RSV_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1});
    send_beat('{mesi_pkg::OP_RSV_FIRST, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0});
    calm = 0;

    // sender pauses until everything has drained
    drain();

    // receiver stalls long while sender keeps offering beats
    hold_off = 1;
    fork
      begin repeat (60) @(negedge clk_i); hold_off = 0; end
      for (int i = 0; i < 30; i++) send_beat(rand_access(next_stamp()));
    join

    // random phases across offset settings
    for (int p = 0; p < 6; p++) begin
      write_offset(ofs_set[p]);
      calm = (p == 2);
      for (int i = 0; i < NRAND / 6; i++) begin
        send_beat(rand_access(stamp_ctr));
        stamp_ctr += $urandom_range(3);
      end
    end
    calm = 0;

    drain();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mesi_pkg.sv
rtl/mesi_l1_cache_controller_unit.sv
bench/testbench.sv
